// ===== hdl/bbhd_pkg.sv =====
// Shared constants and types for the beam-break hysteresis detector.
package bbhd_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned RAW_W     = 16;
   localparam int unsigned LEVEL_W   = 12;
   localparam int unsigned RELEASE_W = 13;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [TIME_W-1:0]    SAMPLE_INTERVAL_US = 32'd1000;
   localparam logic [LEVEL_W-1:0]   FALLBACK_BREAK     = 12'd1500;
   localparam logic [RELEASE_W-1:0] FALLBACK_RELEASE  = 13'd1800;
   localparam logic [LEVEL_W-1:0]   LEVEL_MAX          = 12'd4095;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMBIENT_LEVEL = 1'b0,
      CSR_TRIGGER_DELTA = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   break_level;
      logic [RELEASE_W-1:0] release_level;
   } thr_type;

   typedef struct packed {
      logic                 sample_taken;
      logic                 beam_broken;
      logic                 state_changed;
      logic [LEVEL_W-1:0]   last_level;
      logic [LEVEL_W-1:0]   break_level;
      logic [RELEASE_W-1:0] release_level;
   } result_type;

endpackage

// ===== hdl/bbhd_thresholds.sv =====
// Break and release thresholds derived from the calibration registers.
module bbhd_thresholds (
   input  logic [bbhd_pkg::LEVEL_W-1:0] ambient_level,
   input  logic [bbhd_pkg::LEVEL_W-1:0] trigger_delta,
   output bbhd_pkg::thr_type            thr
);

   logic                              calibrated;
   logic [bbhd_pkg::LEVEL_W-1:0]      cal_break;
   logic [bbhd_pkg::RELEASE_W-1:0]    cal_break_ext;
   logic [bbhd_pkg::RELEASE_W-1:0]    cal_sum;
   logic [bbhd_pkg::RELEASE_W-1:0]    cal_raised;
   logic [bbhd_pkg::RELEASE_W-1:0]    ambient_ext;

   always_comb begin
      calibrated    = (ambient_level != '0) && (trigger_delta != '0) &&
                      (ambient_level >= trigger_delta);
      cal_break     = ambient_level - trigger_delta;
      cal_break_ext = {1'b0, cal_break};
      ambient_ext   = {1'b0, ambient_level};
      cal_sum       = cal_break_ext + {2'b00, trigger_delta[bbhd_pkg::LEVEL_W-1:1]};
      // A delta of one gives no hysteresis, so release is pushed one step above break.
      cal_raised    = (cal_sum <= cal_break_ext) ? cal_break_ext + 13'd1 : cal_sum;
      if (calibrated) begin
         thr.break_level   = cal_break;
         thr.release_level = (cal_raised > ambient_ext) ? ambient_ext : cal_raised;
      end else begin
         thr.break_level   = bbhd_pkg::FALLBACK_BREAK;
         thr.release_level = bbhd_pkg::FALLBACK_RELEASE;
      end
   end

endmodule

// ===== hdl/bbhd_eval.sv =====
// Sample gating, saturation and hysteresis state for one word per cycle.
module bbhd_eval (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [bbhd_pkg::TIME_W-1:0]   time_us,
   input  logic [bbhd_pkg::RAW_W-1:0]    light_sample,
   input  bbhd_pkg::thr_type             thr,
   output bbhd_pkg::result_type          result
);

   logic [bbhd_pkg::TIME_W-1:0]  last_take_ff, last_take_in;
   logic [bbhd_pkg::LEVEL_W-1:0] held_level_ff, held_level_in;
   logic                         broken_ff, broken_in;

   logic [bbhd_pkg::TIME_W-1:0]  elapsed;
   logic                         taken;
   logic [bbhd_pkg::LEVEL_W-1:0] level;
   logic                         next_broken;

   always_comb begin
      // Wrapping subtraction keeps the interval check correct across timer rollover.
      elapsed = time_us - last_take_ff;
      taken   = elapsed >= bbhd_pkg::SAMPLE_INTERVAL_US;
      level   = (light_sample[bbhd_pkg::RAW_W-1:bbhd_pkg::LEVEL_W] != '0) ?
                bbhd_pkg::LEVEL_MAX : light_sample[bbhd_pkg::LEVEL_W-1:0];

      if (!broken_ff) begin
         next_broken = level <= thr.break_level;
      end else begin
         next_broken = !({1'b0, level} >= thr.release_level);
      end

      last_take_in  = last_take_ff;
      held_level_in = held_level_ff;
      broken_in     = broken_ff;
      if (advance && taken) begin
         last_take_in  = time_us;
         held_level_in = level;
         broken_in     = next_broken;
      end

      result.sample_taken  = taken;
      result.beam_broken   = taken ? next_broken : broken_ff;
      result.state_changed = taken && (next_broken != broken_ff);
      result.last_level    = taken ? level : held_level_ff;
      result.break_level   = thr.break_level;
      result.release_level = thr.release_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_take_ff  <= '0;
         held_level_ff <= '0;
         broken_ff     <= 1'b0;
      end else begin
         last_take_ff  <= last_take_in;
         held_level_ff <= held_level_in;
         broken_ff     <= broken_in;
      end
   end

endmodule

// ===== hdl/beam_break_hysteresis_detector.sv =====
// Top level of the beam-break hysteresis detector: input register, evaluation, result register.
// Every accepted word yields exactly one result word, via the input register and then the result
// register; a new word can be accepted in every cycle, with one input register and one result
// register in the path, so the throughput is one word per cycle while rsp_ready stays high. The
// configuration port is always ready and should be written only while no word is in flight.
module beam_break_hysteresis_detector (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bbhd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bbhd_pkg::LEVEL_W-1:0]     csr_data,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bbhd_pkg::TIME_W-1:0]      req_time_us,
   input  logic [bbhd_pkg::RAW_W-1:0]       req_light_sample,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_sample_taken,
   output logic                             rsp_beam_broken,
   output logic                             rsp_state_changed,
   output logic [bbhd_pkg::LEVEL_W-1:0]     rsp_last_level,
   output logic [bbhd_pkg::LEVEL_W-1:0]     rsp_break_level,
   output logic [bbhd_pkg::RELEASE_W-1:0]   rsp_release_level
);

   logic [bbhd_pkg::LEVEL_W-1:0] ambient_ff, ambient_in;
   logic [bbhd_pkg::LEVEL_W-1:0] delta_ff, delta_in;

   logic                         in_valid_ff, in_valid_in;
   logic [bbhd_pkg::TIME_W-1:0]  in_time_ff, in_time_in;
   logic [bbhd_pkg::RAW_W-1:0]   in_sample_ff, in_sample_in;

   logic                         out_valid_ff, out_valid_in;
   bbhd_pkg::result_type         out_ff, out_in;

   bbhd_pkg::thr_type            thr;
   bbhd_pkg::result_type         result;
   logic                         advance;

   bbhd_thresholds u_thresholds (
      .ambient_level (ambient_ff),
      .trigger_delta (delta_ff),
      .thr           (thr)
   );

   bbhd_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .time_us      (in_time_ff),
      .light_sample (in_sample_ff),
      .thr          (thr),
      .result       (result)
   );

   always_comb begin
      csr_ready = 1'b1;
      ambient_in = ambient_ff;
      delta_in   = delta_ff;
      if (csr_valid) begin
         unique case (bbhd_pkg::csr_index_type'(csr_index))
            bbhd_pkg::CSR_AMBIENT_LEVEL: ambient_in = csr_data;
            bbhd_pkg::CSR_TRIGGER_DELTA: delta_in   = csr_data;
            default: ;
         endcase
      end

      // The held word moves on whenever the result register is free or being emptied.
      advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;

      in_valid_in  = in_valid_ff;
      in_time_in   = in_time_ff;
      in_sample_in = in_sample_ff;
      if (req_ready) begin
         in_valid_in  = req_valid;
         in_time_in   = req_time_us;
         in_sample_in = req_light_sample;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ambient_ff   <= '0;
         delta_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ambient_ff   <= ambient_in;
         delta_ff     <= delta_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_time_ff   <= in_time_in;
      in_sample_ff <= in_sample_in;
      out_ff       <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_taken  = out_ff.sample_taken;
   assign rsp_beam_broken   = out_ff.beam_broken;
   assign rsp_state_changed = out_ff.state_changed;
   assign rsp_last_level    = out_ff.last_level;
   assign rsp_break_level   = out_ff.break_level;
   assign rsp_release_level = out_ff.release_level;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the beam-break hysteresis detector.
module tb_top;
   import bbhd_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int TAIL_CYCLES  = 8;
   localparam int PRINT_CAP    = 40;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEVEL_W-1:0]   csr_data;
   logic                 req_valid;
   logic                 req_ready;
   logic [TIME_W-1:0]    req_time_us;
   logic [RAW_W-1:0]     req_light_sample;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_sample_taken;
   logic                 rsp_beam_broken;
   logic                 rsp_state_changed;
   logic [LEVEL_W-1:0]   rsp_last_level;
   logic [LEVEL_W-1:0]   rsp_break_level;
   logic [RELEASE_W-1:0] rsp_release_level;

   // Shadow copy of the registers and of the detector state.
   logic [LEVEL_W-1:0]   shadow_ambient;
   logic [LEVEL_W-1:0]   shadow_delta;
   logic [TIME_W-1:0]    shadow_take_time;
   logic [LEVEL_W-1:0]   shadow_level;
   logic                 shadow_broken;

   result_type           pending_results[$];
   logic [TIME_W-1:0]    stim_time;
   int                   send_idle_pct;
   int                   recv_idle_pct;
   int                   hold_left;
   int                   cycle_count;
   int                   error_count;
   int                   words_sent;
   int                   results_checked;
   int                   taken_seen;
   int                   flips_seen;
   int                   csr_writes;

   beam_break_hysteresis_detector i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_time_us       (req_time_us),
      .req_light_sample  (req_light_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_taken  (rsp_sample_taken),
      .rsp_beam_broken   (rsp_beam_broken),
      .rsp_state_changed (rsp_state_changed),
      .rsp_last_level    (rsp_last_level),
      .rsp_break_level   (rsp_break_level),
      .rsp_release_level (rsp_release_level)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= LIMIT_CYCLES);
      $display("run stopped after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("beam_break_hysteresis_detector regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < PRINT_CAP) begin
         $display("mismatch on result %0d, %s: got %0d, expected %0d", results_checked, what,
                  got, want);
      end
      error_count++;
   endtask

   function automatic void calc_thresholds(output logic [LEVEL_W-1:0] brk_lvl,
                                           output logic [RELEASE_W-1:0] rel_lvl);
      logic        calibrated;
      int unsigned b;
      int unsigned r;
      calibrated = shadow_ambient != 0 && shadow_delta != 0 && shadow_ambient >= shadow_delta;
      if (calibrated) begin
         b = int'(shadow_ambient) - int'(shadow_delta);
         r = b + (shadow_delta >> 1);
      end else begin
         b = FALLBACK_BREAK;
         r = FALLBACK_RELEASE;
      end
      if (r <= b) r = b + 1;
      if (calibrated && r > shadow_ambient) r = shadow_ambient;
      brk_lvl = b[LEVEL_W-1:0];
      rel_lvl = r[RELEASE_W-1:0];
   endfunction

   // Works out the result of one accepted word and advances the shadow state.
   function automatic result_type predict_beam_result(input logic [TIME_W-1:0] t_us,
                                                      input logic [RAW_W-1:0] raw);
      result_type           res;
      logic [LEVEL_W-1:0]   brk_lvl;
      logic [RELEASE_W-1:0] rel_lvl;
      logic [TIME_W-1:0]    elapsed;
      logic [LEVEL_W-1:0]   lvl;
      logic                 next_broken;
      calc_thresholds(brk_lvl, rel_lvl);
      res.sample_taken  = 1'b0;
      res.state_changed = 1'b0;
      elapsed = t_us - shadow_take_time;
      if (elapsed >= SAMPLE_INTERVAL_US) begin
         lvl = (raw > RAW_W'(LEVEL_MAX)) ? LEVEL_MAX : raw[LEVEL_W-1:0];
         next_broken = shadow_broken;
         if (!shadow_broken) begin
            if (lvl <= brk_lvl) next_broken = 1'b1;
         end else begin
            if (RELEASE_W'(lvl) >= rel_lvl) next_broken = 1'b0;
         end
         res.sample_taken  = 1'b1;
         res.state_changed = next_broken != shadow_broken;
         shadow_take_time  = t_us;
         shadow_level      = lvl;
         shadow_broken     = next_broken;
      end
      res.beam_broken   = shadow_broken;
      res.last_level    = shadow_level;
      res.break_level   = brk_lvl;
      res.release_level = rel_lvl;
      return res;
   endfunction

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no word outstanding", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_sample_taken !== want.sample_taken)
               report_mismatch("sample_taken", rsp_sample_taken, want.sample_taken);
            if (rsp_beam_broken !== want.beam_broken)
               report_mismatch("beam_broken", rsp_beam_broken, want.beam_broken);
            if (rsp_state_changed !== want.state_changed)
               report_mismatch("state_changed", rsp_state_changed, want.state_changed);
            if (rsp_last_level !== want.last_level)
               report_mismatch("last_level", rsp_last_level, want.last_level);
            if (rsp_break_level !== want.break_level)
               report_mismatch("break_level", rsp_break_level, want.break_level);
            if (rsp_release_level !== want.release_level)
               report_mismatch("release_level", rsp_release_level, want.release_level);
            taken_seen += want.sample_taken;
            flips_seen += want.state_changed;
         end
         results_checked++;
      end
   end

   // Result side: random stalls, or a long hold-off counted down here.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input logic [TIME_W-1:0] t_us, input logic [RAW_W-1:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_time_us      <= t_us;
      req_light_sample <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_beam_result(t_us, raw));
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [LEVEL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_AMBIENT_LEVEL) shadow_ambient = value;
      else shadow_delta = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_calibration(input int amb, input int dlt);
      wait_drain();
      write_csr(CSR_AMBIENT_LEVEL, LEVEL_W'(amb));
      write_csr(CSR_TRIGGER_DELTA, LEVEL_W'(dlt));
   endtask

   function automatic logic [TIME_W-1:0] next_time();
      case ($urandom_range(9))
         0, 1:    stim_time = stim_time + $urandom_range(999);
         2:       stim_time = stim_time + 999 + $urandom_range(2);
         7:       stim_time = stim_time + $urandom;
         8:       stim_time = $urandom;
         9:       stim_time = stim_time;
         default: stim_time = stim_time + $urandom_range(1000, 3000);
      endcase
      return stim_time;
   endfunction

   // Readings cluster around the thresholds so that the flag toggles often.
   function automatic logic [RAW_W-1:0] pick_light();
      logic [LEVEL_W-1:0]   brk_lvl;
      logic [RELEASE_W-1:0] rel_lvl;
      int                   v;
      calc_thresholds(brk_lvl, rel_lvl);
      case ($urandom_range(9))
         0, 1, 2: v = int'(brk_lvl) + int'($urandom_range(6)) - 3;
         3, 4, 5: v = int'(rel_lvl) + int'($urandom_range(6)) - 3;
         6:       v = int'($urandom_range(4095));
         7:       v = int'($urandom_range(65535));
         default: v = $urandom_range(1) ? 0 : 4095 + int'($urandom_range(1));
      endcase
      if (v < 0) v = 0;
      return v[RAW_W-1:0];
   endfunction

   task automatic pick_calibration();
      int amb;
      int dlt;
      case ($urandom_range(7))
         0: begin amb = 4095; dlt = 4095; end
         1: begin amb = 4095; dlt = 1; end
         2: begin amb = 1; dlt = 1; end
         3: begin amb = 0; dlt = $urandom_range(4095); end
         4: begin amb = $urandom_range(4095); dlt = 0; end
         5: begin amb = $urandom_range(1, 4094); dlt = $urandom_range(amb + 1, 4095); end
         default: begin amb = $urandom_range(1, 4095); dlt = $urandom_range(1, amb); end
      endcase
      set_calibration(amb, dlt);
   endtask

   // Uncalibrated thresholds, interval edges, time wrap and saturation.
   task automatic test_fallback_thresholds();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(32'd0, 16'd0);
      send_word(32'd999, 16'd0);
      send_word(32'd1000, 16'd1500);
      send_word(32'd1500, 16'd4095);
      send_word(32'd2000, 16'd1799);
      send_word(32'd3000, 16'd1800);
      send_word(32'd4000, 16'hFFFF);
      send_word(32'hFFFF_FF00, 16'd0);
      send_word(32'h0000_00E7, 16'd4096);
      send_word(32'h0000_02E8, 16'd1801);
      stim_time = 32'h0000_02E8;
   endtask

   // Each setting gets a word at the break level and one at the release level.
   task automatic test_calibrated_thresholds();
      int                   amb_list[8] = '{2000, 0, 100, 1000, 4095, 4095, 3000, 1};
      int                   dlt_list[8] = '{0, 500, 200, 1000, 1, 4095, 2, 1};
      logic [LEVEL_W-1:0]   brk_lvl;
      logic [RELEASE_W-1:0] rel_lvl;
      for (int k = 0; k < 8; k++) begin
         set_calibration(amb_list[k], dlt_list[k]);
         calc_thresholds(brk_lvl, rel_lvl);
         stim_time += 1000;
         send_word(stim_time, RAW_W'(brk_lvl));
         stim_time += 1000;
         send_word(stim_time, RAW_W'(rel_lvl));
      end
   endtask

   task automatic test_random_traffic(input int n_words, input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int blk = 0; blk < 5; blk++) begin
         pick_calibration();
         for (int i = 0; i < n_words / 5; i++) send_word(next_time(), pick_light());
      end
   endtask

   // The result side holds off while words keep coming, so the input must stall.
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_drain();
      @(posedge clock);
      hold_left = 300;
      @(negedge clock);
      for (int i = 0; i < 40; i++) send_word(next_time(), pick_light());
      wait_drain();
   endtask

   initial begin
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = CSR_AMBIENT_LEVEL;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_time_us      = '0;
      req_light_sample = '0;
      rsp_ready        = 1'b0;
      shadow_ambient   = '0;
      shadow_delta     = '0;
      shadow_take_time = '0;
      shadow_level     = '0;
      shadow_broken    = 1'b0;
      stim_time        = '0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_left        = 0;
      cycle_count      = 0;
      error_count      = 0;
      words_sent       = 0;
      results_checked  = 0;
      taken_seen       = 0;
      flips_seen       = 0;
      csr_writes       = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_fallback_thresholds();
      test_calibrated_thresholds();
      test_random_traffic(610, 29, 86);
      test_random_traffic(610, 86, 29);
      test_random_traffic(610, 0, 0);
      test_result_backpressure();

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("words left without a result", pending_results.size(), 0);

      $display("sent %0d words, checked %0d results over %0d register writes", words_sent,
               results_checked, csr_writes);
      $display("%0d samples taken, %0d beam state flips, %0d mismatches", taken_seen,
               flips_seen, error_count);
      if (error_count == 0) begin
         $display("beam_break_hysteresis_detector regression: pass");
      end else begin
         $display("beam_break_hysteresis_detector regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bbhd_pkg.sv
hdl/bbhd_thresholds.sv
hdl/bbhd_eval.sv
hdl/beam_break_hysteresis_detector.sv
verif/tb_top.sv
